[design/gda_pkg.sv]
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and the month length lookup for the date adder.
// ----------------------------------------------------------------------------
package gda_pkg;

  // Width of the running day remainder; day plus count stays below 2**16.
  localparam int unsigned RemW = 16;

  // Largest year that is carried without wrapping.
  localparam logic [14:0] YearMax = 15'd9999;

  // Year remainder modulo the Gregorian cycle of 400 years.
  localparam logic [8:0] CycleLast = 9'd399;
  localparam logic [RemW-1:0] CycleLen = 16'd400;

  // Month codes that bound the walk.
  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  // Month lengths for a common year; code zero is not a month.
  localparam logic [4:0] MonthLenTab [0:12] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Result of the shared subtract and compare unit.
  typedef struct packed {
    logic [RemW-1:0] diff;
    logic            lt;
    logic            zero;
  } alu_res_t;

  // Length of a month; codes outside one to twelve have length zero.
  function automatic logic [4:0] gda_month_len(input logic [3:0] month,
                                               input logic       leap);
    logic [4:0] len;
    len = 5'd0;
    if (month >= MonthJan && month <= MonthDec) begin
      if (month == MonthFeb) begin
        len = leap ? 5'd29 : 5'd28;
      end else begin
        len = MonthLenTab[month];
      end
    end
    return len;
  endfunction

endpackage

[design/gregorian_date_add_days.sv]
// Throughput: one item at a time; busy stays high until the result strobe.
// The work is done by the single shared subtractor, one step per cycle.
// Reset (rst, synchronous) returns the sequencer to idle and clears done.
// The receiver cannot stall: the result strobe is high for exactly one cycle.
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date by walking month by month, taking
// each month's length off the remainder with one shared subtractor.
// ----------------------------------------------------------------------------
module gregorian_date_add_days
  import gda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [13:0] start_year,
  input  logic [3:0]  start_month,
  input  logic [4:0]  start_day,
  input  logic [14:0] days_to_add,
  output logic        busy,
  output logic        done,
  output logic [13:0] end_year,
  output logic [3:0]  end_month,
  output logic [4:0]  end_day,
  output logic        year_overflow
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMod  = 2'd1;
  localparam logic [1:0] StWalk = 2'd2;

  logic [1:0]      state, state_next;
  logic            done_next;
  logic [13:0]     year;
  logic [3:0]      month;
  logic [RemW-1:0] remain;
  logic [8:0]      r400;
  logic [RemW-1:0] rmod;
  logic            ovf;

  logic [RemW-1:0] alu_a, alu_b;
  alu_res_t        alu_res;
  logic            leap;
  logic [4:0]      mlen;
  logic [14:0]     year_inc;
  logic            year_wrap;
  logic            accept;

  assign accept = start && !busy;
  assign busy   = (state != StIdle);

  // Leap when the year is a multiple of 4 and not of 100, or of 400.
  assign leap = (r400[1:0] == 2'b00) &&
                (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300);
  assign mlen = gda_month_len(month, leap);

  // Next year, wrapping to zero past the largest year.
  assign year_inc  = {1'b0, year} + 15'd1;
  assign year_wrap = (year_inc > YearMax);

  // Operand select for the shared unit.
  always_comb begin
    if (state == StMod) begin
      alu_a = rmod;
      alu_b = CycleLen;
    end else begin
      alu_a = remain;
      alu_b = {{(RemW-5){1'b0}}, mlen};
    end
  end

  gda_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    case (state)
      StIdle: begin
        if (start) begin
          state_next = StMod;
        end
      end
      StMod: begin
        if (alu_res.lt) begin
          state_next = StWalk;
        end
      end
      StWalk: begin
        if (alu_res.lt || alu_res.zero) begin
          state_next = StIdle;
          done_next  = 1'b1;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Working registers of the date walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      year   <= start_year;
      month  <= start_month;
      remain <= {{(RemW-5){1'b0}}, start_day} + {1'b0, days_to_add};
      rmod   <= {2'b00, start_year};
      ovf    <= 1'b0;
    end else if (state == StMod) begin
      if (!alu_res.lt) begin
        rmod <= alu_res.diff;
      end else begin
        r400 <= rmod[8:0];
      end
    end else if (state == StWalk && !(alu_res.lt || alu_res.zero)) begin
      remain <= alu_res.diff;
      if (month >= MonthDec) begin
        month <= MonthJan;
        if (year_wrap) begin
          year <= '0;
          r400 <= '0;
          ovf  <= 1'b1;
        end else begin
          year <= year_inc[13:0];
          r400 <= (r400 == CycleLast) ? 9'd0 : r400 + 9'd1;
        end
      end else begin
        month <= month + 4'd1;
      end
    end
  end

  assign end_year      = year;
  assign end_month     = month;
  assign end_day       = remain[4:0];
  assign year_overflow = ovf;

`ifndef ASSERT_OFF
  // The result strobe only comes once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");

  // The final remainder always fits in the day field.
  a_day_fits: assert property (@(posedge clk) disable iff (rst)
    done |-> (remain[RemW-1:5] == '0))
    else $error("day remainder too wide at done");

  // The 400-year remainder stays reduced during the walk.
  a_r400_range: assert property (@(posedge clk) disable iff (rst)
    (state == StWalk) |-> (r400 <= CycleLast))
    else $error("year remainder out of range");

  // An accepted item makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted item did not start");

  // The strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
`endif

endmodule

[design/gda_alu.sv]
// ----------------------------------------------------------------------------
// gda_alu
// Shared subtractor with less-than and zero flags, used both for the year
// reduction modulo 400 and for taking month lengths off the day remainder.
// ----------------------------------------------------------------------------
module gda_alu
  import gda_pkg::*;
(
  input  logic [RemW-1:0] a,
  input  logic [RemW-1:0] b,
  output alu_res_t        res
);

  logic [RemW:0] wide;

  // One subtraction; the borrow out tells that a is below b.
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[RemW-1:0];
  assign res.lt   = wide[RemW];
  assign res.zero = (wide[RemW-1:0] == '0);

endmodule

[test/gregorian_date_add_days_tb.sv]
// ----------------------------------------------------------------------------
// gregorian_date_add_days_tb
// Self-checking bench for the date adder. Each accepted item is run through
// a month-by-month date walk kept here, and every result strobe is compared
// field by field with the oldest outstanding prediction. Stimulus covers
// directed corner dates, year wrap and out-of-range codes, then random items
// sent in bursts with random gaps or with no gaps at all.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_tb;

  // Calendar bounds used by the predictor.
  localparam int unsigned YearTop  = 9999;
  localparam int unsigned MonthJan = 1;
  localparam int unsigned MonthFeb = 2;
  localparam int unsigned MonthDec = 12;

  // Run control: idle cycles tolerated and the quiet tail after the last item.
  localparam int StallLimit = 6000;
  localparam int TailCycles = 1200;
  localparam int ShownErrors = 10;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        wrapped;
  } date_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [13:0] start_year = '0;
  logic [3:0]  start_month = '0;
  logic [4:0]  start_day = '0;
  logic [14:0] days_to_add = '0;
  logic        busy;
  logic        done;
  logic [13:0] end_year;
  logic [3:0]  end_month;
  logic [4:0]  end_day;
  logic        year_overflow;

  date_res_t due_dates[$];
  int        bad_count = 0;
  int        burst_left = 0;
  int        result_count = 0;

  gregorian_date_add_days dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .days_to_add  (days_to_add),
    .busy         (busy),
    .done         (done),
    .end_year     (end_year),
    .end_month    (end_month),
    .end_day      (end_day),
    .year_overflow(year_overflow)
  );

  always #5 clk = ~clk;

  // Days in a month; codes outside January to December have no days.
  function automatic int unsigned month_days(int unsigned yr, int unsigned mo);
    logic leap;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    case (mo)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      MonthFeb:              return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Walk forward one month at a time until the remaining days fit.
  function automatic date_res_t advance_date(int unsigned yr, int unsigned mo,
                                             int unsigned day, int unsigned count);
    date_res_t   res;
    int unsigned remain;
    int unsigned len;
    logic        wrapped;
    remain  = day + count;
    wrapped = 1'b0;
    len     = month_days(yr, mo);
    while (remain > len) begin
      remain = remain - len;
      mo = mo + 1;
      if (mo > MonthDec) begin
        mo = MonthJan;
        yr = yr + 1;
        if (yr > YearTop) begin
          yr      = 0;
          wrapped = 1'b1;
        end
      end
      len = month_days(yr, mo);
    end
    res.year    = yr[13:0];
    res.month   = mo[3:0];
    res.day     = remain[4:0];
    res.wrapped = wrapped;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    bad_count++;
    if (bad_count <= ShownErrors) begin
      $display("%0t: result %0d: %s", $realtime, result_count, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
    end
  endtask

  // Present one item and hold start until it is taken. Start stays high
  // afterwards so that a following item can go out with no gap.
  task automatic issue_date(input int unsigned yr, input int unsigned mo,
                            input int unsigned day, input int unsigned count);
    start       <= 1'b1;
    start_year  <= yr[13:0];
    start_month <= mo[3:0];
    start_day   <= day[4:0];
    days_to_add <= count[14:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    due_dates.push_back(advance_date(yr, mo, day, count));
  endtask

  // Bursts of random length separated by random gaps, some of them long.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                        : $urandom_range(0, 25);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop start and wait until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (due_dates.size() != 0) @(posedge clk);
  endtask

  // A valid date with a count that is mostly short, sometimes the full range;
  // the rest of the time any bit pattern the ports allow.
  task automatic issue_random_date(input int noise_pct);
    int unsigned yr;
    int unsigned mo;
    int unsigned day;
    int unsigned count;
    int unsigned pick;
    if ($urandom_range(0, 99) < noise_pct) begin
      yr    = $urandom_range(0, 16383);
      mo    = $urandom_range(0, 15);
      day   = $urandom_range(0, 31);
      count = $urandom & 32'h7FFF;
    end else begin
      yr  = ($urandom_range(0, 9) == 0) ? $urandom_range(9900, YearTop)
                                        : $urandom_range(0, YearTop);
      mo  = $urandom_range(MonthJan, MonthDec);
      day = $urandom_range(1, month_days(yr, mo));
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        count = $urandom_range(0, 400);
      end else if (pick < 8) begin
        count = $urandom_range(0, 3000);
      end else if (pick < 9) begin
        count = $urandom_range(0, 32767);
      end else begin
        count = $urandom_range(32000, 32767);
      end
    end
    issue_date(yr, mo, day, count);
  endtask

  // Corner dates sent back to back.
  task automatic test_directed();
    issue_date(2024, 1, 1, 0);
    issue_date(0, 0, 0, 0);
    issue_date(16383, 15, 31, 32767);
    issue_date(9999, 12, 31, 1);
    issue_date(9999, 12, 31, 32767);
    issue_date(2000, 2, 28, 1);
    issue_date(1900, 2, 28, 1);
    issue_date(2024, 2, 28, 1);
    issue_date(2023, 2, 28, 1);
    issue_date(2023, 12, 31, 1);
    issue_date(2023, 0, 5, 10);
    issue_date(2023, 13, 1, 0);
    issue_date(2023, 15, 20, 40);
    issue_date(2023, 5, 0, 0);
    issue_date(2023, 4, 31, 0);
    issue_date(2023, 2, 31, 0);
    issue_date(10000, 6, 1, 300);
    issue_date(12345, 12, 1, 31);
    issue_date(0, 1, 1, 32767);
    issue_date(2023, 1, 31, 32767);
    issue_date(8191, 7, 16, 16384);
    drain_results();
  endtask

  // Dates near the year limit, past it, and on century leap boundaries.
  task automatic test_year_edges();
    int unsigned yr;
    int unsigned mo;
    int unsigned day;
    int unsigned count;
    for (int i = 0; i < 40; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          yr    = YearTop - $urandom_range(0, 89);
          mo    = $urandom_range(MonthJan, MonthDec);
          day   = $urandom_range(1, 28);
          count = $urandom_range(0, 32767);
        end
        1: begin
          yr    = $urandom_range(YearTop + 1, 16383);
          mo    = $urandom_range(0, 15);
          day   = $urandom_range(0, 31);
          count = $urandom_range(0, 2000);
        end
        2: begin
          yr    = 100 * $urandom_range(0, 99);
          mo    = MonthFeb;
          day   = $urandom_range(1, 29);
          count = $urandom_range(0, 3);
        end
        default: begin
          yr    = 400 * $urandom_range(0, 24) + $urandom_range(0, 3);
          mo    = MonthDec;
          day   = 31;
          count = $urandom_range(0, 800);
        end
      endcase
      issue_date(yr, mo, day, count);
      pace_sender();
    end
    drain_results();
  endtask

  // Bulk of the run: mostly valid dates, some noise, random pacing.
  task automatic test_random_dates();
    for (int i = 0; i < 440; i++) begin
      issue_random_date(15);
      pace_sender();
    end
    drain_results();
  endtask

  // Let the block run dry, then send the next burst with no gaps at all.
  task automatic test_pressure();
    for (int round = 0; round < 5; round++) begin
      repeat ($urandom_range(2, 8)) issue_random_date(10);
      drain_results();
    end
  endtask

  // Compare every result strobe with the oldest prediction.
  always @(posedge clk) begin : check_results
    date_res_t want;
    if (!rst && done) begin
      result_count++;
      if (due_dates.size() == 0) begin
        flag_error("result with no item outstanding");
      end else begin
        want = due_dates.pop_front();
        check_field("end_year", 16'(want.year), 16'(end_year));
        check_field("end_month", 16'(want.month), 16'(end_month));
        check_field("end_day", 16'(want.day), 16'(end_day));
        check_field("year_overflow", 16'(want.wrapped), 16'(year_overflow));
      end
    end
  end

  // End the run if neither an item nor a result moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("gregorian_date_add_days_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_year_edges();
    test_random_dates();
    test_pressure();
    repeat (TailCycles) @(posedge clk);
    if (due_dates.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", due_dates.size()));
    end
    if (bad_count == 0) begin
      $display("gregorian_date_add_days_tb: done, clean");
    end else begin
      $display("gregorian_date_add_days_tb: done, errors");
    end
    $finish;
  end

endmodule
